/* hw/rtl/dla_pkg.sv */
package dla_pkg;

    typedef enum logic [2:0] {
        ST_ACTIVE   = 3'd0,
        ST_OFFLINE  = 3'd1,
        ST_STALE    = 3'd2,
        ST_ARCHIVED = 3'd3,
        ST_DELETED  = 3'd4
    } t_state;

    typedef enum logic [1:0] {
        FN_OBSERVE  = 2'd0,
        FN_CTRL_OK  = 2'd1,
        FN_CTRL_BAD = 2'd2,
        FN_MAINT    = 2'd3
    } t_func;

    localparam logic [1:0] RET_NORMAL    = 2'd0;
    localparam logic [1:0] RET_TEMPORARY = 2'd1;
    localparam logic [1:0] RET_PINNED    = 2'd2;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_ARCHIVED = 2'd1;
    localparam logic [1:0] EV_DELETED  = 2'd2;

    localparam logic [1:0] CFG_OFFLINE = 2'd0;
    localparam logic [1:0] CFG_STALE   = 2'd1;
    localparam logic [1:0] CFG_ARCHIVE = 2'd2;
    localparam logic [1:0] CFG_PURGE   = 2'd3;

    localparam logic [31:0] OFFLINE_RST = 32'd300;
    localparam logic [31:0] STALE_RST   = 32'd3600;
    localparam logic [31:0] ARCHIVE_RST = 32'd86400;
    localparam logic [31:0] PURGE_RST   = 32'd604800;

    // temporary retention divides every timeout by four
    localparam int TEMP_SHIFT = 2;

    typedef struct packed {
        logic [31:0] offline_after;
        logic [31:0] stale_after;
        logic [31:0] archive_after;
        logic [31:0] purge_after;
    } t_thresh;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  cur_state;
        logic [1:0]  retention;
        logic [31:0] seen_time;
        logic [31:0] archive_time;
        logic [31:0] now_time;
        logic [31:0] seen_count;
        logic [31:0] used_count;
        logic [31:0] failed_count;
        logic [31:0] revision_in;
        logic        online_in;
    } t_rec_in;

    typedef struct packed {
        logic [2:0]  new_state;
        logic [31:0] seen_time_out;
        logic [31:0] archive_time_out;
        logic [31:0] success_time_out;
        logic        success_time_valid;
        logic [31:0] modified_time;
        logic [31:0] seen_count_out;
        logic [31:0] used_count_out;
        logic [31:0] failed_count_out;
        logic [31:0] revision_out;
        logic        online_out;
        logic [1:0]  event_out;
    } t_rec_out;

endpackage

/* hw/rtl/device_lifecycle_aging.sv */
// a word passes through the input register and then the result register
// throughput: one word per cycle while i_out_ready holds; the critical path is one 33-bit
// subtract and compare against the selected timeout in the update stage
// reset (synchronous, active low) empties both pipeline stages and loads the
// four timeouts with their defaults (300, 3600, 86400, 604800 s)
module device_lifecycle_aging (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,

    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [2:0]  i_cur_state,
    input  logic [1:0]  i_retention,
    input  logic [31:0] i_seen_time,
    input  logic [31:0] i_archive_time,
    input  logic [31:0] i_now_time,
    input  logic [31:0] i_seen_count,
    input  logic [31:0] i_used_count,
    input  logic [31:0] i_failed_count,
    input  logic [31:0] i_revision_in,
    input  logic        i_online_in,

    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_new_state,
    output logic [31:0] o_seen_time_out,
    output logic [31:0] o_archive_time_out,
    output logic [31:0] o_success_time_out,
    output logic        o_success_time_valid,
    output logic [31:0] o_modified_time,
    output logic [31:0] o_seen_count_out,
    output logic [31:0] o_used_count_out,
    output logic [31:0] o_failed_count_out,
    output logic [31:0] o_revision_out,
    output logic        o_online_out,
    output logic [1:0]  o_event_out
);

    // timeout registers
    dla_pkg::t_thresh  r_thr;

    // input register stage
    logic              r_s1_valid;
    dla_pkg::t_rec_in  r_s1;

    // result register stage
    logic              r_out_valid;
    dla_pkg::t_rec_out r_out;

    dla_pkg::t_rec_in  in_rec;
    dla_pkg::t_rec_out upd_rec;
    logic              in_take;
    logic              out_load;

    // result stage frees up when empty or when its word leaves this cycle;
    // the input stage may refill whenever its word moves on
    assign out_load   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || out_load;
    assign in_take    = i_in_valid && o_in_ready;

    assign in_rec = '{
        func:         i_func,
        cur_state:    i_cur_state,
        retention:    i_retention,
        seen_time:    i_seen_time,
        archive_time: i_archive_time,
        now_time:     i_now_time,
        seen_count:   i_seen_count,
        used_count:   i_used_count,
        failed_count: i_failed_count,
        revision_in:  i_revision_in,
        online_in:    i_online_in
    };

    // configuration writes, taken at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.offline_after <= dla_pkg::OFFLINE_RST;
            r_thr.stale_after   <= dla_pkg::STALE_RST;
            r_thr.archive_after <= dla_pkg::ARCHIVE_RST;
            r_thr.purge_after   <= dla_pkg::PURGE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dla_pkg::CFG_OFFLINE: r_thr.offline_after <= i_cfg_data;
                dla_pkg::CFG_STALE:   r_thr.stale_after   <= i_cfg_data;
                dla_pkg::CFG_ARCHIVE: r_thr.archive_after <= i_cfg_data;
                dla_pkg::CFG_PURGE:   r_thr.purge_after   <= i_cfg_data;
                default:              r_thr.purge_after   <= r_thr.purge_after;
            endcase
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= in_rec;
        end
        if (out_load) begin
            r_out <= upd_rec;
        end
    end

    // record update between the two register stages
    dla_update u_update (
        .i_rec (r_s1),
        .i_thr (r_thr),
        .o_rec (upd_rec)
    );

    assign o_out_valid          = r_out_valid;
    assign o_new_state          = r_out.new_state;
    assign o_seen_time_out      = r_out.seen_time_out;
    assign o_archive_time_out   = r_out.archive_time_out;
    assign o_success_time_out   = r_out.success_time_out;
    assign o_success_time_valid = r_out.success_time_valid;
    assign o_modified_time      = r_out.modified_time;
    assign o_seen_count_out     = r_out.seen_count_out;
    assign o_used_count_out     = r_out.used_count_out;
    assign o_failed_count_out   = r_out.failed_count_out;
    assign o_revision_out       = r_out.revision_out;
    assign o_online_out         = r_out.online_out;
    assign o_event_out          = r_out.event_out;

    // an accepted word always lands in the input stage
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_s1_valid)
        else $error("accepted word lost before the update stage");

    // a word held in the input stage keeps its contents
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_load) |=> (r_s1_valid && $stable(r_s1)))
        else $error("input stage word changed while stalled");

    // archive event only with the archived state and a fresh archive stamp
    a_arch_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_out == dla_pkg::EV_ARCHIVED) |->
        (r_out.new_state == dla_pkg::ST_ARCHIVED &&
         r_out.archive_time_out == r_out.modified_time))
        else $error("archive event without archiving");

    // a delete event (which also bumps the revision) lands in soft deleted with no success stamp
    a_del_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_out == dla_pkg::EV_DELETED) |->
        (r_out.new_state == dla_pkg::ST_DELETED && !r_out.success_time_valid))
        else $error("delete event without soft delete");

endmodule

/* hw/rtl/dla_update.sv */
module dla_update (
    input  dla_pkg::t_rec_in  i_rec,
    input  dla_pkg::t_thresh  i_thr,
    output dla_pkg::t_rec_out o_rec
);

    logic [31:0] thr_raw;
    logic [31:0] thr;
    logic [31:0] stamp;
    logic [32:0] diff;
    logic        due;
    logic        pinned;
    logic        moved;

    // timeout and time stamp that apply to the current state
    always_comb begin
        thr_raw = i_thr.offline_after;
        stamp   = i_rec.seen_time;
        case (i_rec.cur_state)
            dla_pkg::ST_OFFLINE:  thr_raw = i_thr.stale_after;
            dla_pkg::ST_STALE:    thr_raw = i_thr.archive_after;
            dla_pkg::ST_ARCHIVED: begin
                thr_raw = i_thr.purge_after;
                stamp   = i_rec.archive_time;
            end
            default:              thr_raw = i_thr.offline_after;
        endcase
    end

    assign thr    = (i_rec.retention == dla_pkg::RET_TEMPORARY) ?
                    (thr_raw >> dla_pkg::TEMP_SHIFT) : thr_raw;
    assign diff   = {1'b0, i_rec.now_time} - {1'b0, stamp};
    // never-set stamp counts as zero elapsed; a future stamp never expires
    assign due    = (stamp == 32'd0) ? (thr == 32'd0) :
                    (!diff[32] && (diff[31:0] >= thr));
    assign pinned = (i_rec.retention == dla_pkg::RET_PINNED);

    always_comb begin
        o_rec                    = '0;
        o_rec.new_state          = i_rec.cur_state;
        o_rec.seen_time_out      = i_rec.seen_time;
        o_rec.archive_time_out   = i_rec.archive_time;
        o_rec.seen_count_out     = i_rec.seen_count;
        o_rec.used_count_out     = i_rec.used_count;
        o_rec.failed_count_out   = i_rec.failed_count;
        o_rec.online_out         = i_rec.online_in;
        o_rec.event_out          = dla_pkg::EV_NONE;
        moved                    = 1'b0;
        case (i_rec.func)
            dla_pkg::FN_OBSERVE, dla_pkg::FN_CTRL_OK: begin
                if (i_rec.func == dla_pkg::FN_OBSERVE) begin
                    o_rec.seen_time_out  = i_rec.now_time;
                    o_rec.seen_count_out = i_rec.seen_count + 32'd1;
                end else begin
                    o_rec.success_time_out   = i_rec.now_time;
                    o_rec.success_time_valid = 1'b1;
                    o_rec.used_count_out     = i_rec.used_count + 32'd1;
                end
                o_rec.modified_time = i_rec.now_time;
                o_rec.online_out    = 1'b1;
                if (i_rec.cur_state == dla_pkg::ST_OFFLINE ||
                    i_rec.cur_state == dla_pkg::ST_STALE ||
                    i_rec.cur_state == dla_pkg::ST_ARCHIVED) begin
                    o_rec.new_state = dla_pkg::ST_ACTIVE;
                    moved           = 1'b1;
                end
            end
            dla_pkg::FN_CTRL_BAD: begin
                o_rec.failed_count_out = i_rec.failed_count + 32'd1;
                o_rec.modified_time    = i_rec.now_time;
            end
            default: begin
                case (i_rec.cur_state)
                    dla_pkg::ST_ACTIVE: begin
                        if (due) begin
                            o_rec.online_out = 1'b0;
                            o_rec.new_state  = dla_pkg::ST_OFFLINE;
                            moved            = 1'b1;
                        end
                    end
                    dla_pkg::ST_OFFLINE: begin
                        if (due) begin
                            o_rec.new_state = dla_pkg::ST_STALE;
                            moved           = 1'b1;
                        end
                    end
                    dla_pkg::ST_STALE: begin
                        if (due && !pinned) begin
                            o_rec.archive_time_out = i_rec.now_time;
                            o_rec.new_state        = dla_pkg::ST_ARCHIVED;
                            o_rec.event_out        = dla_pkg::EV_ARCHIVED;
                            moved                  = 1'b1;
                        end
                    end
                    dla_pkg::ST_ARCHIVED: begin
                        if (due && !pinned) begin
                            o_rec.new_state = dla_pkg::ST_DELETED;
                            o_rec.event_out = dla_pkg::EV_DELETED;
                            moved           = 1'b1;
                        end
                    end
                    default: moved = 1'b0;
                endcase
                if (moved) begin
                    o_rec.modified_time = i_rec.now_time;
                end
            end
        endcase
        o_rec.revision_out = moved ? (i_rec.revision_in + 32'd1) : i_rec.revision_in;
    end

endmodule
